// ===== rtl/assert_macros.svh =====
// Assertion macros used by the verification checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define KRTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset cycles included.
`define KRTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/krts_pkg.sv =====
// Types and constants of the key repeat time setter.
package krts_pkg;

    // Key codes
    localparam logic [2:0] KEY_NONE  = 3'd0;
    localparam logic [2:0] KEY_PRESS = 3'd1;
    localparam logic [2:0] KEY_LEFT  = 3'd2;
    localparam logic [2:0] KEY_RIGHT = 3'd3;
    localparam logic [2:0] KEY_UP    = 3'd4;
    localparam logic [2:0] KEY_DOWN  = 3'd5;

    // Timer commands
    localparam logic [1:0] TCMD_NONE = 2'd0;
    localparam logic [1:0] TCMD_STOP = 2'd1;
    localparam logic [1:0] TCMD_RUN  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_DELAY  = 2'd0;
    localparam logic [1:0] CFG_HOLD_DELAY   = 2'd1;
    localparam logic [1:0] CFG_REPEAT_DELAY = 2'd2;

    // Configuration reset values
    localparam logic [7:0] FIRST_DELAY_RST  = 8'd15;
    localparam logic [7:0] HOLD_DELAY_RST   = 8'd150;
    localparam logic [7:0] REPEAT_DELAY_RST = 8'd30;

    // Repeat stages
    localparam logic [1:0] STAGE_FIRST  = 2'd0;
    localparam logic [1:0] STAGE_HOLD   = 2'd1;
    localparam logic [1:0] STAGE_REPEAT = 2'd2;

    localparam logic [5:0]  TIME_MAX   = 6'd59;
    localparam logic [12:0] DISP_SCALE = 13'd100;

    typedef struct packed {
        logic [7:0] first_delay;
        logic [7:0] hold_delay;
        logic [7:0] repeat_delay;
    } t_delays;

    typedef struct packed {
        logic [2:0] key_code;
        logic       system_active;
        logic [5:0] counter_minute;
        logic [5:0] counter_second;
    } t_in;

    typedef struct packed {
        logic        in_set_mode;
        logic        editing_minutes;
        logic [5:0]  set_minute_out;
        logic [5:0]  set_second_out;
        logic        display_update;
        logic [12:0] display_value;
        logic        beep;
        logic [1:0]  timer_command;
        logic        led_toggle;
        logic        report_time;
    } t_out;

    // minute * 100 + second, kept to 13 bits
    function automatic logic [12:0] show_time(input logic [5:0] minute,
                                              input logic [5:0] second);
        logic [12:0] prod;
        begin
            prod = {7'd0, minute} * DISP_SCALE;
            show_time = prod + {7'd0, second};
        end
    endfunction

endpackage

// ===== rtl/key_repeat_time_setter.sv =====
// Top level of the key repeat time setter: config registers and result register.
//
// One transaction per scan tick. An accepted tick is debounced, qualified for
// auto-repeat and applied to the set time in the same cycle; its result sits
// in the output register from the next cycle on. A new transaction is taken
// every cycle (one item per clock) unless a result waits for the consumer and
// does not leave the output register in the same cycle, so throughput is set
// only by the output register handshake. The user must write the delays
// through the plain write port only while no transaction is in flight; the
// block itself does not enforce this.
module key_repeat_time_setter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  krts_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output krts_pkg::t_out    o_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);
    import krts_pkg::*;

    t_delays    r_delays;
    logic       r_out_valid;
    t_out       r_out;
    t_out       result;
    logic       accept;
    logic       consume;
    logic [2:0] pending;

    assign o_ready = i_rst_n && (!r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delays.first_delay  <= FIRST_DELAY_RST;
            r_delays.hold_delay   <= HOLD_DELAY_RST;
            r_delays.repeat_delay <= REPEAT_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_DELAY:  r_delays.first_delay  <= i_cfg_data;
                CFG_HOLD_DELAY:   r_delays.hold_delay   <= i_cfg_data;
                CFG_REPEAT_DELAY: r_delays.repeat_delay <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    krts_qualifier u_qualifier (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (accept),
        .i_key     (i_data.key_code),
        .i_delays  (r_delays),
        .i_consume (consume),
        .o_pending (pending)
    );

    krts_setter u_setter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (accept),
        .i_active         (i_data.system_active),
        .i_counter_minute (i_data.counter_minute),
        .i_counter_second (i_data.counter_second),
        .i_pending        (pending),
        .o_consume        (consume),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the payload while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/krts_qualifier.sv =====
// Key debounce and auto-repeat qualifier with the pending key latch.
module krts_qualifier (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [2:0]       i_key,
    input  krts_pkg::t_delays i_delays,
    input  logic             i_consume,
    output logic [2:0]       o_pending
);
    import krts_pkg::*;

    logic [2:0] r_prev_key;
    logic [7:0] r_stable;
    logic [1:0] r_stage;
    logic [2:0] r_pending;
    logic [7:0] n_stable;
    logic [1:0] n_stage;
    logic [2:0] n_pending;
    logic [7:0] wait_ticks;

    always_comb begin
        case (r_stage)
            STAGE_FIRST: wait_ticks = i_delays.first_delay;
            STAGE_HOLD:  wait_ticks = i_delays.hold_delay;
            default:     wait_ticks = i_delays.repeat_delay;
        endcase

        n_stable  = r_stable;
        n_stage   = r_stage;
        n_pending = r_pending;
        if (i_key == KEY_NONE || i_key != r_prev_key) begin
            n_stable  = 8'd0;
            n_stage   = STAGE_FIRST;
            n_pending = KEY_NONE;
        end else if (r_stable < wait_ticks) begin
            n_stable = r_stable + 8'd1;
        end else begin
            // fire: latch the key, advance the stage up to the repeat stage
            n_pending = i_key;
            n_stable  = 8'd0;
            if (r_stage != STAGE_REPEAT) begin
                n_stage = r_stage + 2'd1;
            end
        end
    end

    assign o_pending = n_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_key <= KEY_NONE;
            r_stable   <= 8'd0;
            r_stage    <= STAGE_FIRST;
            r_pending  <= KEY_NONE;
        end else if (i_en) begin
            r_prev_key <= i_key;
            r_stable   <= n_stable;
            r_stage    <= n_stage;
            r_pending  <= i_consume ? KEY_NONE : n_pending;
        end
    end

endmodule

// ===== rtl/krts_setter.sv =====
// Set mode state and the action of a fired key on the set time.
module krts_setter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_active,
    input  logic [5:0]    i_counter_minute,
    input  logic [5:0]    i_counter_second,
    input  logic [2:0]    i_pending,
    output logic          o_consume,
    output krts_pkg::t_out o_result
);
    import krts_pkg::*;

    logic       r_set_mode;
    logic       r_min_sel;
    logic [5:0] r_minute;
    logic [5:0] r_second;
    logic       n_set_mode;
    logic       n_min_sel;
    logic [5:0] n_minute;
    logic [5:0] n_second;

    always_comb begin
        n_set_mode = r_set_mode;
        n_min_sel  = r_min_sel;
        n_minute   = r_minute;
        n_second   = r_second;
        o_consume  = 1'b0;

        o_result = '0;
        o_result.timer_command = TCMD_NONE;

        if (i_active) begin
            case (i_pending)
                KEY_PRESS: begin
                    o_consume = 1'b1;
                    o_result.display_update = 1'b1;
                    o_result.beep = 1'b1;
                    o_result.led_toggle = 1'b1;
                    if (!r_set_mode) begin
                        o_result.display_value = show_time(r_minute, r_second);
                        n_set_mode = 1'b1;
                        n_min_sel  = 1'b0;
                        o_result.timer_command = TCMD_STOP;
                        o_result.report_time = 1'b1;
                    end else begin
                        o_result.display_value =
                            show_time(i_counter_minute, i_counter_second);
                        n_set_mode = 1'b0;
                        o_result.timer_command = TCMD_RUN;
                    end
                end
                KEY_LEFT, KEY_RIGHT: begin
                    o_consume = 1'b1;
                    if (r_set_mode) begin
                        n_min_sel = !r_min_sel;
                    end
                end
                KEY_UP: begin
                    o_consume = 1'b1;
                    if (r_set_mode) begin
                        if (r_min_sel) begin
                            n_minute = (r_minute >= TIME_MAX) ? 6'd0 : r_minute + 6'd1;
                        end else begin
                            n_second = (r_second >= TIME_MAX) ? 6'd0 : r_second + 6'd1;
                        end
                        o_result.display_update = 1'b1;
                        o_result.display_value = show_time(n_minute, n_second);
                    end
                end
                KEY_DOWN: begin
                    o_consume = 1'b1;
                    if (r_set_mode) begin
                        if (r_min_sel) begin
                            n_minute = (r_minute != 6'd0) ? r_minute - 6'd1 : TIME_MAX;
                        end else begin
                            n_second = (r_second != 6'd0) ? r_second - 6'd1 : TIME_MAX;
                        end
                        o_result.display_update = 1'b1;
                        o_result.display_value = show_time(n_minute, n_second);
                    end
                end
                default: begin
                    // unused codes stay pending
                end
            endcase
        end

        o_result.in_set_mode     = n_set_mode;
        o_result.editing_minutes = n_min_sel;
        o_result.set_minute_out  = n_minute;
        o_result.set_second_out  = n_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_mode <= 1'b0;
            r_min_sel  <= 1'b0;
            r_minute   <= 6'd0;
            r_second   <= 6'd0;
        end else if (i_en) begin
            r_set_mode <= n_set_mode;
            r_min_sel  <= n_min_sel;
            r_minute   <= n_minute;
            r_second   <= n_second;
        end
    end

endmodule

// ===== rtl/krts_checker.sv =====
// Port-level checker for the key repeat time setter, bound to the top level.
`include "assert_macros.svh"

module krts_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_ready,
    input krts_pkg::t_out o_data
);
    import krts_pkg::*;

    `KRTS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_data), "result changed while stalled")
    `KRTS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result valid right after reset")
    `KRTS_ASSERT(a_disp_zero, i_clk, i_rst_n, o_valid && !o_data.display_update |-> o_data.display_value == 13'd0, "display value without update")
    `KRTS_ASSERT(a_press_events, i_clk, i_rst_n, o_valid && o_data.beep |-> o_data.led_toggle && o_data.display_update && (o_data.timer_command == TCMD_STOP || o_data.timer_command == TCMD_RUN), "press events incomplete")
    `KRTS_ASSERT(a_enter_set, i_clk, i_rst_n, o_valid && o_data.timer_command == TCMD_STOP |-> o_data.in_set_mode && o_data.report_time && !o_data.editing_minutes, "stop command without set mode entry")

endmodule

bind key_repeat_time_setter krts_checker u_krts_checker (.*);
